@@ src/cbam_pkg.sv @@
// Package for the cartridge bus address mirroring block.
// Holds store sizes, operation codes, the decoded command and the result types.
// No dependencies; the front end, queue, back end and top level import it.
package cbam_pkg;

	localparam int CPU_DEPTH       = 65536;
	localparam int PPU_DEPTH       = 16384;
	localparam int CPU_AW          = $clog2(CPU_DEPTH);
	localparam int PPU_AW          = $clog2(PPU_DEPTH);
	localparam int QUEUE_DEPTH_DEF = 2;

	// Configuration port.
	localparam int CFG_IW = 1;
	localparam int CFG_DW = 1;
	localparam logic [CFG_IW-1:0] CFG_MIRROR_VERTICAL = 1'd0;
	localparam logic [CFG_IW-1:0] CFG_PRG_IS_32K      = 1'd1;

	typedef enum logic [1:0] {
		OP_CPU_READ  = 2'd0,
		OP_CPU_WRITE = 2'd1,
		OP_PPU_READ  = 2'd2,
		OP_PPU_WRITE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		TGT_NONE = 2'd0,
		TGT_CPU  = 2'd1,
		TGT_PPU  = 2'd2
	} tgt_t;

	// Decoded access, as it waits in the queue.
	typedef struct packed {
		tgt_t              tgt;
		logic              wr;
		logic [CPU_AW-1:0] addr;
		logic [7:0]        wdata;
		logic              fwd;
		logic [2:0]        idx;
		logic              reg_wr;
		logic [7:0]        fwd_byte;
	} cmd_t;

	typedef struct packed {
		logic [7:0] read_byte;
		logic       to_ppu_register;
		logic [2:0] register_index;
		logic       register_write;
		logic [7:0] forwarded_byte;
	} res_t;

endpackage

@@ src/cbam_ram.sv @@
// Generic single-port RAM with a registered read.
// Depends on nothing; instantiated by the back end for both byte stores.
module cbam_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end
			rdata <= mem[addr];
		end
	end

endmodule

@@ src/cbam_front.sv @@
// Front end: configuration registers, input handshake and address decode.
// Depends on cbam_pkg; pushes decoded commands into cbam_queue.
module cbam_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [cbam_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [cbam_pkg::CFG_DW-1:0]  cfg_data,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [23:0]                  s_tdata,
	input  logic [1:0]                   s_tuser,
	input  logic                         q_full,
	input  logic                         clearing,
	output logic                         push,
	output cbam_pkg::cmd_t               cmd
);
	import cbam_pkg::*;

	localparam logic [15:0] RAM_LAST     = 16'h1FFF;
	localparam logic [15:0] PPU_REG_LAST = 16'h2007;
	localparam logic [15:0] DMA_PORT     = 16'h4014;
	localparam logic [15:0] EXP_FIRST    = 16'h4020;
	localparam logic [15:0] EXP_LAST     = 16'h5FFF;
	localparam logic [15:0] PRG_FIRST    = 16'h8000;
	localparam logic [13:0] NT_FIRST     = 14'h2000;
	localparam logic [13:0] NT_END       = 14'h3000;
	localparam logic [13:0] FOLD_LAST    = 14'h3EFF;
	localparam logic [13:0] FOLD_STEP    = 14'h1000;
	localparam logic [13:0] NT_1         = 14'h2400;
	localparam logic [13:0] NT_2         = 14'h2800;
	localparam logic [13:0] PAL_BASE     = 14'h3F00;
	localparam logic [13:0] PAL_LAST     = 14'h3F1F;

	logic mirror_vertical_q;
	logic prg_is_32k_q;

	op_t         op;
	logic [15:0] a;
	logic [7:0]  d;
	logic [13:0] pa;
	logic [13:0] pmap;
	logic [9:0]  off;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mirror_vertical_q <= 1'b0;
			prg_is_32k_q      <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MIRROR_VERTICAL: mirror_vertical_q <= cfg_data[0];
				CFG_PRG_IS_32K:      prg_is_32k_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign s_tready = !clearing && !q_full;
	assign push     = s_tvalid && s_tready;

	assign op = op_t'(s_tuser);
	assign a  = s_tdata[15:0];
	assign d  = s_tdata[23:16];

	// PPU address map: wrap, nametable fold, mirroring and palette.
	always_comb begin
		pa = a[13:0];
		if (pa >= NT_END && pa <= FOLD_LAST) begin
			pa = pa - FOLD_STEP;
		end
		off = pa[9:0];
		if (pa < NT_FIRST) begin
			pmap = pa;
		end else if (pa < NT_END) begin
			unique case (pa[11:10])
				2'd0: pmap = pa;
				2'd1: pmap = mirror_vertical_q ? pa : (NT_FIRST + {4'b0, off});
				2'd2: pmap = mirror_vertical_q ? (NT_FIRST + {4'b0, off}) : pa;
				2'd3: pmap = mirror_vertical_q ? (NT_1 + {4'b0, off}) : (NT_2 + {4'b0, off});
				default: pmap = pa;
			endcase
		end else if (pa <= PAL_LAST) begin
			pmap = pa;
		end else begin
			pmap = PAL_BASE + {9'b0, pa[4:0]};
		end
	end

	always_comb begin
		cmd.tgt      = TGT_CPU;
		cmd.wr       = s_tuser[0];
		cmd.addr     = a;
		cmd.wdata    = d;
		cmd.fwd      = 1'b0;
		cmd.idx      = 3'd0;
		cmd.reg_wr   = 1'b0;
		cmd.fwd_byte = 8'd0;
		unique case (op)
			OP_PPU_READ, OP_PPU_WRITE: begin
				cmd.tgt  = TGT_PPU;
				cmd.addr = {2'b00, pmap};
			end
			OP_CPU_READ, OP_CPU_WRITE: begin
				priority if (a <= RAM_LAST) begin
					cmd.addr = {5'b0, a[10:0]};
				end else if (a <= PPU_REG_LAST || a == DMA_PORT) begin
					// The DMA port lands on register 4, the same as its low three bits.
					cmd.tgt      = TGT_NONE;
					cmd.fwd      = 1'b1;
					cmd.idx      = a[2:0];
					cmd.reg_wr   = s_tuser[0];
					cmd.fwd_byte = s_tuser[0] ? d : 8'd0;
				end else if (a >= EXP_FIRST && a <= EXP_LAST) begin
					cmd.tgt = TGT_NONE;
				end else if (a >= PRG_FIRST) begin
					cmd.addr = prg_is_32k_q ? a : {2'b10, a[13:0]};
				end else begin
					cmd.addr = a;
				end
			end
			default: ;
		endcase
	end

endmodule

@@ src/cbam_queue.sv @@
// Short FIFO of decoded commands between the front and the back end.
// Depends on cbam_pkg for the command type.
module cbam_queue #(
	parameter int QUEUE_DEPTH = cbam_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cbam_pkg::cmd_t push_cmd,
	input  logic           pop,
	output logic           full,
	output logic           not_empty,
	output cbam_pkg::cmd_t head
);
	import cbam_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cmd_t          entry_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == CW'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ src/cbam_back.sv @@
// Back end: clearing pass, store accesses and the output register.
// Depends on cbam_pkg and cbam_ram; pops commands from cbam_queue.
module cbam_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  cbam_pkg::cmd_t q_cmd,
	output logic           pop,
	output logic           clearing,
	output logic           m_tvalid,
	input  logic           m_tready,
	output cbam_pkg::res_t res
);
	import cbam_pkg::*;

	logic              clearing_q;
	logic [CPU_AW-1:0] clr_cnt_q;

	logic              valid_s1;
	tgt_t              tgt_s1;
	logic              wr_s1;
	logic              fwd_s1;
	logic [2:0]        idx_s1;
	logic              reg_wr_s1;
	logic [7:0]        fwd_byte_s1;

	logic              out_valid_q;
	res_t              res_q;

	logic              cpu_en;
	logic              cpu_we;
	logic [CPU_AW-1:0] cpu_addr;
	logic [7:0]        cpu_wdata;
	logic [7:0]        cpu_rdata;
	logic              ppu_en;
	logic              ppu_we;
	logic [PPU_AW-1:0] ppu_addr;
	logic [7:0]        ppu_wdata;
	logic [7:0]        ppu_rdata;
	logic [7:0]        rd_byte;

	// One access in flight; the output register must be free by the time it lands.
	assign pop      = !clearing_q && q_valid && !valid_s1 && (!out_valid_q || m_tready);
	assign clearing = clearing_q;

	always_comb begin
		if (clearing_q) begin
			cpu_en    = 1'b1;
			cpu_we    = 1'b1;
			cpu_addr  = clr_cnt_q;
			cpu_wdata = 8'd0;
			ppu_en    = 1'b1;
			ppu_we    = 1'b1;
			ppu_addr  = clr_cnt_q[PPU_AW-1:0];
			ppu_wdata = 8'd0;
		end else begin
			cpu_en    = pop && (q_cmd.tgt == TGT_CPU);
			cpu_we    = q_cmd.wr;
			cpu_addr  = q_cmd.addr;
			cpu_wdata = q_cmd.wdata;
			ppu_en    = pop && (q_cmd.tgt == TGT_PPU);
			ppu_we    = q_cmd.wr;
			ppu_addr  = q_cmd.addr[PPU_AW-1:0];
			ppu_wdata = q_cmd.wdata;
		end
	end

	cbam_ram #(.WIDTH(8), .DEPTH(CPU_DEPTH)) u_cpu_ram (
		.clk   (clk),
		.en    (cpu_en),
		.we    (cpu_we),
		.addr  (cpu_addr),
		.wdata (cpu_wdata),
		.rdata (cpu_rdata)
	);

	cbam_ram #(.WIDTH(8), .DEPTH(PPU_DEPTH)) u_ppu_ram (
		.clk   (clk),
		.en    (ppu_en),
		.we    (ppu_we),
		.addr  (ppu_addr),
		.wdata (ppu_wdata),
		.rdata (ppu_rdata)
	);

	always_comb begin
		unique case (tgt_s1)
			TGT_CPU: rd_byte = wr_s1 ? 8'd0 : cpu_rdata;
			TGT_PPU: rd_byte = wr_s1 ? 8'd0 : ppu_rdata;
			default: rd_byte = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q  <= 1'b1;
			clr_cnt_q   <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == CPU_AW'(CPU_DEPTH - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			valid_s1 <= pop;
			if (valid_s1) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			tgt_s1      <= q_cmd.tgt;
			wr_s1       <= q_cmd.wr;
			fwd_s1      <= q_cmd.fwd;
			idx_s1      <= q_cmd.idx;
			reg_wr_s1   <= q_cmd.reg_wr;
			fwd_byte_s1 <= q_cmd.fwd_byte;
		end
		if (valid_s1) begin
			res_q.read_byte       <= rd_byte;
			res_q.to_ppu_register <= fwd_s1;
			res_q.register_index  <= idx_s1;
			res_q.register_write  <= reg_wr_s1;
			res_q.forwarded_byte  <= fwd_byte_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign res      = res_q;

endmodule

@@ src/cartridge_bus_address_mirroring.sv @@
// Top level of the cartridge bus address mirroring block.
// Depends on cbam_pkg, cbam_front, cbam_queue and cbam_back.
//
// Channel  Direction  Handshake           Payload
// s_*      in         s_tvalid/s_tready   s_tdata: bus_address, write_byte; s_tuser: operation
// m_*      out        m_tvalid/m_tready   m_tdata: read_byte, register_index, forwarded_byte;
//                                         m_tuser: to_ppu_register, register_write
// cfg_*    in         cfg_we              cfg_index, cfg_data
//
// An accepted transaction passes through the queue, the registered RAM read with the stage-1
// registers, and the output register before it shows on m_*. The back end keeps one store
// access in flight, so it pops no new command while the last one is still in stage 1.
// After reset a clearing pass zeroes both stores; s_tready stays low meanwhile, configuration
// writes are taken as ever. The queue holds QUEUE_DEPTH decoded transactions, so input keeps
// flowing while m_tready is low until the queue is full.
module cartridge_bus_address_mirroring #(
	parameter int QUEUE_DEPTH = cbam_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [cbam_pkg::CFG_IW-1:0] cfg_index,
	input  logic [cbam_pkg::CFG_DW-1:0] cfg_data,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [23:0]                 s_tdata,   // bus_address[15:0], write_byte[23:16]
	input  logic [1:0]                  s_tuser,   // operation[1:0]
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [23:0]                 m_tdata,   // read_byte[7:0], register_index[10:8],
	                                               // forwarded_byte[18:11], zero [23:19]
	output logic [1:0]                  m_tuser    // to_ppu_register[0], register_write[1]
);
	import cbam_pkg::*;

	logic push;
	logic pop;
	logic q_full;
	logic q_valid;
	logic clearing;
	cmd_t push_cmd;
	cmd_t head;
	res_t res;

	cbam_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.q_full    (q_full),
		.clearing  (clearing),
		.push      (push),
		.cmd       (push_cmd)
	);

	cbam_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_valid),
		.head      (head)
	);

	cbam_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_cmd    (head),
		.pop      (pop),
		.clearing (clearing),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.res      (res)
	);

	assign m_tdata = {5'b0, res.forwarded_byte, res.register_index, res.read_byte};
	assign m_tuser = {res.register_write, res.to_ppu_register};

endmodule

@@ src/cbam_checker.sv @@
// Port-level checker for the cartridge bus address mirroring block.
// Depends on nothing beyond the top level's ports; bound to the top level at the end of this file.
module cbam_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic [1:0]  m_tuser
);

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Register fields stay zero unless the transaction is forwarded.
	a_no_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[18:8] == 11'd0 && !m_tuser[1])
		else $error("register fields set on a store access");

	// A forwarded transaction reads nothing from a store.
	a_fwd_read: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[7:0] == 8'd0)
		else $error("read byte set on a forwarded access");

	// Only a forwarded write carries a byte.
	a_fwd_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[1] |-> m_tdata[18:11] == 8'd0 && m_tdata[23:19] == 5'd0)
		else $error("forwarded byte set without a register write");

endmodule

bind cartridge_bus_address_mirroring cbam_checker u_checker (.*);
